/* hdl/soil_pkg.sv */
// Shared types and constants for the self-organizing intersection light block.
package soil_pkg;

	localparam int ROWS = 16;
	localparam int COLS = 16;
	localparam int DEPTH = ROWS * COLS;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam int TIMER_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_GREEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_THRESH = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PLATOON = 2'd3;

	typedef enum logic [1:0] {
		PH_V   = 2'd0,
		PH_H   = 2'd1,
		PH_RED = 2'd2
	} phase_t;

	typedef struct packed {
		logic [3:0]  row;
		logic [3:0]  col;
		logic        stop_h;
		logic        stop_v;
		logic [7:0]  approach_h;
		logic [7:0]  approach_v;
		logic [7:0]  near_h;
		logic [7:0]  near_v;
		logic [15:0] sum_h;
		logic [15:0] sum_v;
	} item_t;

	typedef struct packed {
		logic [3:0] out_row;
		logic [3:0] out_col;
		logic       green_h;
		logic       green_v;
		logic       changed;
		logic       clear_sum_h;
		logic       clear_sum_v;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic update;
	} cmd_t;

endpackage

/* hdl/soil_datapath.sv */
// Datapath: configuration registers, phase and timer memory, rule evaluation, result register.
module soil_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  soil_pkg::cmd_t                cmd,
	input  soil_pkg::item_t               item,
	input  logic                          cfg_wen,
	input  logic [soil_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [soil_pkg::CFG_DATA_W-1:0] cfg_data,
	output soil_pkg::result_t             result
);

	localparam int ENTRY_W = 2 + soil_pkg::TIMER_W;

	logic [15:0] min_green_q;
	logic [15:0] max_red_q;
	logic [15:0] count_thresh_q;
	logic [7:0]  platoon_q;

	logic [ENTRY_W-1:0] mem [soil_pkg::DEPTH];
	logic [soil_pkg::DEPTH-1:0] vld_q;

	soil_pkg::item_t            item_q;
	logic [3:0]                 row_sat_q;
	logic [3:0]                 col_sat_q;
	logic [soil_pkg::IDX_W-1:0] idx_q;
	logic [ENTRY_W-1:0]         rd_data_q;
	logic                       rd_valid_q;
	soil_pkg::result_t          result_q;

	logic [3:0]                 row_sat;
	logic [3:0]                 col_sat;
	logic [soil_pkg::IDX_W-1:0] idx;

	logic [1:0]                     ph_cur;
	logic [soil_pkg::TIMER_W-1:0]   t_cur;
	logic [soil_pkg::TIMER_W-1:0]   t_inc;
	logic [1:0]                     ph_next;
	logic [soil_pkg::TIMER_W-1:0]   t_next;
	logic                           sw;
	logic                           red;
	logic                           clr_h;
	logic                           clr_v;
	logic                           g_stop;
	logic                           r_stop;
	logic [7:0]                     g_app;
	logic [7:0]                     r_app;
	logic [7:0]                     g_near;
	logic [15:0]                    r_sum;
	logic                           is_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_green_q <= '0;
			max_red_q <= '0;
			count_thresh_q <= '0;
			platoon_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				soil_pkg::REG_MIN_GREEN: min_green_q <= cfg_data;
				soil_pkg::REG_MAX_RED: max_red_q <= cfg_data;
				soil_pkg::REG_COUNT_THRESH: count_thresh_q <= cfg_data;
				soil_pkg::REG_PLATOON: platoon_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Out-of-range street indexes saturate to the last street.
	always_comb begin
		row_sat = (32'(item.row) >= soil_pkg::ROWS) ? 4'(soil_pkg::ROWS - 1) : item.row;
		col_sat = (32'(item.col) >= soil_pkg::COLS) ? 4'(soil_pkg::COLS - 1) : item.col;
		idx = soil_pkg::IDX_W'(32'(row_sat) * soil_pkg::COLS + 32'(col_sat));
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
			row_sat_q <= row_sat;
			col_sat_q <= col_sat;
			idx_q <= idx;
			rd_data_q <= mem[idx];
		end
		if (cmd.update) begin
			mem[idx_q] <= {ph_next, t_next};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				rd_valid_q <= vld_q[idx];
			end
			if (cmd.update) begin
				vld_q[idx_q] <= 1'b1;
			end
		end
	end

	// An entry never written holds the reset state: vertical green, timer zero.
	always_comb begin
		ph_cur = rd_valid_q ? rd_data_q[ENTRY_W-1 -: 2] : soil_pkg::PH_V;
		t_cur = rd_valid_q ? rd_data_q[soil_pkg::TIMER_W-1:0] : '0;
		t_inc = (t_cur == '1) ? t_cur : t_cur + 1'b1;

		is_h = (ph_cur == soil_pkg::PH_H);
		g_stop = is_h ? item_q.stop_h : item_q.stop_v;
		r_stop = is_h ? item_q.stop_v : item_q.stop_h;
		g_app = is_h ? item_q.approach_h : item_q.approach_v;
		r_app = is_h ? item_q.approach_v : item_q.approach_h;
		g_near = is_h ? item_q.near_h : item_q.near_v;
		r_sum = is_h ? item_q.sum_v : item_q.sum_h;

		sw = 1'b0;
		red = 1'b0;
		clr_h = 1'b0;
		clr_v = 1'b0;
		ph_next = ph_cur;
		t_next = t_inc;

		case (ph_cur)
			soil_pkg::PH_V, soil_pkg::PH_H: begin
				if (g_stop) begin
					if (r_stop) red = 1'b1;
					else sw = 1'b1;
				end else if (!r_stop) begin
					if (r_app != '0 && g_app == '0) begin
						sw = 1'b1;
					end else if (!(g_near != '0 && g_near < platoon_q)) begin
						if (t_inc >= min_green_q
						    && (r_sum >= count_thresh_q || t_inc >= max_red_q)) begin
							sw = 1'b1;
						end
					end
				end
				if (red) begin
					ph_next = soil_pkg::PH_RED;
					t_next = '0;
				end else if (sw) begin
					t_next = '0;
					if (is_h) begin
						ph_next = soil_pkg::PH_V;
						clr_v = 1'b1;
					end else begin
						ph_next = soil_pkg::PH_H;
						clr_h = 1'b1;
					end
				end
			end
			default: begin
				// All red, and the unused code that behaves like it.
				if (!item_q.stop_h) begin
					ph_next = soil_pkg::PH_H;
					t_next = '0;
				end else if (!item_q.stop_v) begin
					ph_next = soil_pkg::PH_V;
					t_next = '0;
				end else begin
					ph_next = soil_pkg::PH_RED;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			result_q.out_row <= row_sat_q;
			result_q.out_col <= col_sat_q;
			result_q.green_h <= (ph_next == soil_pkg::PH_H);
			result_q.green_v <= (ph_next == soil_pkg::PH_V);
			result_q.changed <= sw;
			result_q.clear_sum_h <= clr_h;
			result_q.clear_sum_v <= clr_v;
		end
	end

	assign result = result_q;

endmodule

/* hdl/soil_ctrl.sv */
// Controller: sequences capture, table update and the result handshake.
module soil_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	output logic           result_valid,
	input  logic           result_stall,
	output soil_pkg::cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_UPDATE
	} state_t;

	state_t state_q;
	logic   result_valid_q;

	assign item_stall = (state_q != ST_IDLE);
	assign cmd.capture = item_valid && (state_q == ST_IDLE);
	// The update waits only when the previous result still sits unclaimed.
	assign cmd.update = (state_q == ST_UPDATE) && (!result_valid_q || !result_stall);
	assign result_valid = result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.capture) state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (cmd.update) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.update) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* hdl/self_organizing_intersection_lights.sv */
// Top level of the self-organizing intersection light controller.
// Each transaction on the item channel is one tick for one intersection and yields exactly
// one transaction on the result channel. Items are handled one at a time: the intersection's
// phase and timer entry is read from the state memory when the item is captured, then the
// switching rules are applied and the entry is written back in the update state; a new item
// is taken only after that write-back. A finished result waits in an output register, and the next
// item is accepted meanwhile. The state memory needs no clearing pass: a valid bit per entry,
// cleared by reset, makes unwritten entries read as vertical green with a zero timer.
// Configuration registers may be written only while no transaction is in flight.
module self_organizing_intersection_lights (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  soil_pkg::item_t                 item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output soil_pkg::result_t               result,
	input  logic                            cfg_wen,
	input  logic [soil_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [soil_pkg::CFG_DATA_W-1:0] cfg_data
);

	soil_pkg::cmd_t cmd;

	soil_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd)
	);

	soil_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.item      (item),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

endmodule

/* hdl/soil_checker.sv */
// Port-level checker for the intersection light block, with its bind statement.
module soil_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input logic              result_valid,
	input logic              result_stall,
	input soil_pkg::result_t result
);

	// A waiting result is not withdrawn.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result withdrawn while stalled");

	// Items are handled one at a time, so the item channel is busy right after a transaction.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item accepted on consecutive cycles");

	a_one_green: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.green_h && result.green_v))
		else $error("both roads green");

	// A clear request goes only with a swap, and only for the road that turned green.
	a_clear_matches_swap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.clear_sum_h == (result.changed && result.green_h))
			&& (result.clear_sum_v == (result.changed && result.green_v)))
		else $error("clear request does not match the swap");

	a_swap_gives_green: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.changed |-> result.green_h || result.green_v)
		else $error("swap left all red");

endmodule

bind self_organizing_intersection_lights soil_checker u_soil_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

/* dv/self_organizing_intersection_lights_tb.sv */
// Self-checking testbench for the self-organizing intersection light controller.
module self_organizing_intersection_lights_tb;

	localparam int unsigned CYCLE_LIMIT = 500_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic item_valid = 1'b0;
	logic item_stall;
	soil_pkg::item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	soil_pkg::result_t result;
	logic cfg_wen = 1'b0;
	logic [soil_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [soil_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	self_organizing_intersection_lights dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Mirror of the intersection table and the register file.
	soil_pkg::phase_t phase_mem [soil_pkg::DEPTH];
	logic [soil_pkg::TIMER_W-1:0] timer_mem [soil_pkg::DEPTH];
	logic [15:0] min_green;
	logic [15:0] max_red;
	logic [15:0] count_thr;
	logic [7:0] platoon_lim;

	soil_pkg::item_t pending_items [$];
	soil_pkg::result_t expected_lights [$];
	soil_pkg::result_t want_lights;

	int n_queued = 0;
	int n_accepted = 0;
	int n_results = 0;
	int n_settings = 0;
	int mismatches = 0;
	int unsigned cycle_count = 0;

	logic feed_en = 1'b0;
	logic idle_on = 1'b0;
	int send_idle = 0;
	int recv_idle = 0;

	// Applies one tick to the mirrored table and returns the lights it should report.
	function automatic soil_pkg::result_t next_lights(input soil_pkg::item_t it);
		int unsigned r, c, idx, t;
		logic [7:0] g_app, r_app, g_near;
		logic [15:0] r_sum;
		bit on_h, g_stop, r_stop, sw, red, clr_h, clr_v;
		soil_pkg::phase_t ph;
		soil_pkg::result_t res;
		r = 32'(it.row);
		c = 32'(it.col);
		if (r >= soil_pkg::ROWS) r = soil_pkg::ROWS - 1;
		if (c >= soil_pkg::COLS) c = soil_pkg::COLS - 1;
		idx = r * soil_pkg::COLS + c;
		ph = phase_mem[idx];
		t = 32'(timer_mem[idx]);
		if (t < 32'hFFFF) t++;
		sw = 1'b0;
		red = 1'b0;
		clr_h = 1'b0;
		clr_v = 1'b0;
		if (ph == soil_pkg::PH_H || ph == soil_pkg::PH_V) begin
			on_h = (ph == soil_pkg::PH_H);
			g_stop = on_h ? it.stop_h : it.stop_v;
			r_stop = on_h ? it.stop_v : it.stop_h;
			g_app = on_h ? it.approach_h : it.approach_v;
			r_app = on_h ? it.approach_v : it.approach_h;
			g_near = on_h ? it.near_h : it.near_v;
			r_sum = on_h ? it.sum_v : it.sum_h;
			if (g_stop) begin
				if (r_stop) red = 1'b1;
				else sw = 1'b1;
			end else if (!r_stop) begin
				if (r_app != '0 && g_app == '0) begin
					sw = 1'b1;
				end else if (!(g_near != '0 && g_near < platoon_lim)) begin
					// A short platoon near the green road holds off the timer and count switch.
					if (t >= 32'(min_green) && (r_sum >= count_thr || t >= 32'(max_red)))
						sw = 1'b1;
				end
			end
			if (red) begin
				ph = soil_pkg::PH_RED;
				t = 0;
			end else if (sw) begin
				if (on_h) begin
					ph = soil_pkg::PH_V;
					clr_v = 1'b1;
				end else begin
					ph = soil_pkg::PH_H;
					clr_h = 1'b1;
				end
				t = 0;
			end
		end else begin
			if (!it.stop_h) begin
				ph = soil_pkg::PH_H;
				t = 0;
			end else if (!it.stop_v) begin
				ph = soil_pkg::PH_V;
				t = 0;
			end else begin
				ph = soil_pkg::PH_RED;
			end
		end
		phase_mem[idx] = ph;
		timer_mem[idx] = t[15:0];
		res.out_row = r[3:0];
		res.out_col = c[3:0];
		res.green_h = (ph == soil_pkg::PH_H);
		res.green_v = (ph == soil_pkg::PH_V);
		res.changed = sw;
		res.clear_sum_h = clr_h;
		res.clear_sum_v = clr_v;
		return res;
	endfunction

	function automatic soil_pkg::item_t make_item(input int r, input int c,
			input int sh, input int sv, input int ah, input int av,
			input int nh, input int nv, input int suh, input int suv);
		soil_pkg::item_t it;
		it.row = 4'(r);
		it.col = 4'(c);
		it.stop_h = 1'(sh);
		it.stop_v = 1'(sv);
		it.approach_h = 8'(ah);
		it.approach_v = 8'(av);
		it.near_h = 8'(nh);
		it.near_v = 8'(nv);
		it.sum_h = 16'(suh);
		it.sum_v = 16'(suv);
		return it;
	endfunction

	function automatic logic [7:0] pick_count();
		case ($urandom_range(0, 2))
			0: return 8'd0;
			1: return 8'($urandom_range(1, 7));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Accumulated counts cluster around the threshold so both sides of it are hit.
	function automatic logic [15:0] pick_sum();
		int v;
		case ($urandom_range(0, 3))
			0: return 16'd0;
			1: begin
				v = int'(count_thr) + int'($urandom_range(0, 4)) - 2;
				if (v < 0) v = 0;
				if (v > 65535) v = 65535;
				return 16'(v);
			end
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic soil_pkg::item_t rand_item();
		soil_pkg::item_t it;
		if ($urandom_range(0, 9) < 6) begin
			// A few busy intersections so timers build up between switches.
			it.row = 4'($urandom_range(0, 1));
			it.col = 4'($urandom_range(0, 1));
		end else begin
			it.row = 4'($urandom_range(0, 15));
			it.col = 4'($urandom_range(0, 15));
		end
		it.stop_h = ($urandom_range(0, 4) == 0);
		it.stop_v = ($urandom_range(0, 4) == 0);
		it.approach_h = pick_count();
		it.approach_v = pick_count();
		it.near_h = pick_count();
		it.near_v = pick_count();
		it.sum_h = pick_sum();
		it.sum_v = pick_sum();
		return it;
	endfunction

	task automatic queue_item(input soil_pkg::item_t it);
		pending_items.push_back(it);
		n_queued++;
	endtask

	task automatic set_reg(input logic [soil_pkg::CFG_IDX_W-1:0] idx,
			input logic [soil_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			soil_pkg::REG_MIN_GREEN: min_green = data;
			soil_pkg::REG_MAX_RED: max_red = data;
			soil_pkg::REG_COUNT_THRESH: count_thr = data;
			soil_pkg::REG_PLATOON: platoon_lim = data[7:0];
			default: ;
		endcase
	endtask

	task automatic program_lights(input int unsigned mg, input int unsigned mr,
			input int unsigned ct, input int unsigned pl);
		set_reg(soil_pkg::REG_MIN_GREEN, 16'(mg));
		set_reg(soil_pkg::REG_MAX_RED, 16'(mr));
		set_reg(soil_pkg::REG_COUNT_THRESH, 16'(ct));
		// The upper byte of the platoon write carries junk that must be dropped.
		set_reg(soil_pkg::REG_PLATOON, {8'($urandom_range(0, 255)), 8'(pl)});
		n_settings++;
	endtask

	// Releases the queued items and waits until every result has come back.
	task automatic run_batch(input bit idle);
		@(posedge clk);
		feed_en <= 1'b1;
		idle_on <= idle;
		do @(negedge clk);
		while (!(n_accepted == n_queued && expected_lights.size() == 0));
		@(posedge clk);
		feed_en <= 1'b0;
		repeat (6) @(posedge clk);
	endtask

	task automatic random_batch(input int n, input bit idle);
		repeat (n) queue_item(rand_item());
		run_batch(idle);
	endtask

	// Item driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			send_idle <= 0;
		end else begin
			if (item_valid && !item_stall) begin
				expected_lights.push_back(next_lights(item));
				n_accepted++;
			end
			if (!item_valid || !item_stall) begin
				if (send_idle != 0) begin
					send_idle <= send_idle - 1;
					item_valid <= 1'b0;
				end else if (!feed_en || pending_items.size() == 0) begin
					item_valid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 15) == 0) begin
					send_idle <= $urandom_range(0, 15);
					item_valid <= 1'b0;
				end else begin
					item <= pending_items.pop_front();
					item_valid <= 1'b1;
				end
			end
		end
	end

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Result monitor and receiver-side stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			recv_idle <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_lights.size() == 0) begin
					$error("unexpected result transaction: row %0d col %0d",
						result.out_row, result.out_col);
					mismatches++;
				end else begin
					want_lights = expected_lights.pop_front();
					check_field("out_row", 32'(want_lights.out_row), 32'(result.out_row));
					check_field("out_col", 32'(want_lights.out_col), 32'(result.out_col));
					check_field("green_h", 32'(want_lights.green_h), 32'(result.green_h));
					check_field("green_v", 32'(want_lights.green_v), 32'(result.green_v));
					check_field("changed", 32'(want_lights.changed), 32'(result.changed));
					check_field("clear_sum_h", 32'(want_lights.clear_sum_h),
						32'(result.clear_sum_h));
					check_field("clear_sum_v", 32'(want_lights.clear_sum_v),
						32'(result.clear_sum_v));
					n_results++;
				end
			end
			if (recv_idle != 0) begin
				recv_idle <= recv_idle - 1;
				result_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 15) == 0) begin
				recv_idle <= $urandom_range(0, 15);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("[self_organizing_intersection_lights] ERROR");
		$finish;
	end

	initial begin
		int leftovers;
		for (int i = 0; i < soil_pkg::DEPTH; i++) begin
			phase_mem[i] = soil_pkg::PH_V;
			timer_mem[i] = '0;
		end
		min_green = '0;
		max_red = '0;
		count_thr = '0;
		platoon_lim = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: every unobstructed tick swaps the green.
		queue_item(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		queue_item(make_item(0, 0, 1, 1, 0, 0, 0, 0, 0, 0));
		// All red with both roads still stopped stays all red.
		queue_item(make_item(0, 0, 1, 1, 0, 0, 0, 0, 0, 0));
		queue_item(make_item(0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
		queue_item(make_item(0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
		queue_item(make_item(0, 0, 1, 1, 0, 0, 0, 0, 0, 0));
		queue_item(make_item(0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
		queue_item(make_item(15, 15, 1, 1, 255, 255, 255, 255, 65535, 65535));
		queue_item(make_item(15, 15, 0, 0, 255, 255, 255, 255, 65535, 65535));
		queue_item(make_item(15, 15, 0, 1, 255, 255, 255, 255, 65535, 65535));
		queue_item(make_item(15, 0, 0, 0, 9, 0, 0, 0, 0, 0));
		queue_item(make_item(0, 15, 0, 0, 0, 0, 0, 200, 0, 0));
		run_batch(1'b1);

		// Minimum green, count threshold, timeout and platoon hold.
		program_lights(3, 6, 100, 5);
		queue_item(make_item(3, 4, 0, 0, 1, 1, 0, 0, 0, 0));
		queue_item(make_item(3, 4, 0, 0, 1, 1, 0, 0, 0, 0));
		queue_item(make_item(3, 4, 0, 0, 1, 1, 0, 0, 100, 0));
		queue_item(make_item(3, 4, 0, 0, 1, 1, 4, 0, 0, 65535));
		queue_item(make_item(3, 4, 0, 0, 1, 1, 4, 0, 0, 65535));
		queue_item(make_item(3, 4, 0, 0, 1, 1, 4, 0, 0, 65535));
		queue_item(make_item(3, 4, 0, 0, 1, 1, 5, 0, 0, 0));
		queue_item(make_item(3, 4, 0, 0, 1, 1, 5, 0, 0, 0));
		queue_item(make_item(3, 4, 0, 0, 1, 1, 5, 0, 0, 0));
		// Demand only on the red road wins over a held platoon.
		queue_item(make_item(7, 7, 0, 0, 3, 0, 0, 2, 0, 0));
		queue_item(make_item(7, 7, 0, 0, 0, 3, 0, 0, 0, 99));
		run_batch(1'b1);

		program_lights(0, 0, 0, 0);
		random_batch(240, 1'b1);
		program_lights(65535, 65535, 65535, 255);
		random_batch(240, 1'b1);
		program_lights(0, 65535, 65535, 0);
		random_batch(240, 1'b1);
		program_lights(2, 8, 300, 6);
		random_batch(240, 1'b1);
		program_lights($urandom_range(0, 10), $urandom_range(0, 30),
			$urandom_range(0, 500), $urandom_range(0, 12));
		random_batch(240, 1'b1);
		program_lights($urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 65535), $urandom_range(0, 255));
		random_batch(240, 1'b1);

		program_lights(1, 4, 50, 3);
		random_batch(240, 1'b0);

		leftovers = expected_lights.size();
		if (leftovers != 0) $error("%0d expected results never arrived", leftovers);
		$display("Covered %0d item transactions under %0d register settings,", n_accepted,
			n_settings + 1);
		$display("with stalls on both channels; %0d results checked, %0d mismatches.",
			n_results, mismatches);
		if (mismatches == 0 && leftovers == 0) begin
			$display("[self_organizing_intersection_lights] OK");
		end else begin
			$display("[self_organizing_intersection_lights] ERROR");
		end
		$finish;
	end

endmodule

/* filelist.f */
hdl/soil_pkg.sv
hdl/soil_datapath.sv
hdl/soil_ctrl.sv
hdl/self_organizing_intersection_lights.sv
hdl/soil_checker.sv
dv/self_organizing_intersection_lights_tb.sv
